>>> hdl/assert_macros.svh
// Assertion macros shared by the sitda RTL files.
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the queue entry type; no dependencies.
`timescale 1ns / 1ps
package sitda_pkg;
    localparam int MAG_W         = 32;
    localparam int DIGITS        = 10;
    localparam int DIGIT_W       = 4;
    localparam int DIGIT_IDX_W   = $clog2(DIGITS);
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int CHAR_W        = 7;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    // One converted value waiting for the emitter.
    typedef struct packed {
        logic negative;
        bcd_t digits;
    } entry_t;
endpackage

>>> hdl/sitda_front.sv
// Front end: takes a value, splits sign and magnitude, converts to BCD.
// Depends on sitda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sitda_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [31:0]            value,
    output logic                          busy,
    input  logic                          q_full,
    output logic                          q_push,
    output sitda_pkg::entry_t             q_entry
);
    typedef enum logic [1:0] {IDLE, CONV, PUSH} state_t;

    state_t                                state_reg;
    logic [sitda_pkg::STEP_W-1:0]          step_reg;
    logic                                  neg_reg;
    logic [sitda_pkg::MAG_W-1:0]           mag_reg;
    logic [sitda_pkg::BCD_W-1:0]           bcd_reg;
    logic [sitda_pkg::MAG_W-1:0]           mag_next;
    logic [sitda_pkg::BCD_W-1:0]           bcd_next;
    logic                                  accept;
    logic                                  conv_done;

    assign accept    = start && (state_reg == IDLE);
    assign busy      = (state_reg != IDLE);
    assign q_push    = (state_reg == PUSH) && !q_full;
    assign q_entry   = '{negative: neg_reg, digits: sitda_pkg::bcd_t'(bcd_reg)};
    assign conv_done = (state_reg == CONV)
                    && (step_reg == sitda_pkg::STEP_W'(sitda_pkg::CONV_STEPS - 1));

    // Double dabble, several magnitude bits per cycle.
    always_comb
    begin
        logic [sitda_pkg::BCD_W-1:0] t;
        logic [sitda_pkg::MAG_W-1:0] m;
        t = bcd_reg;
        m = mag_reg;
        for (int i = 0; i < sitda_pkg::BITS_PER_STEP; i++)
        begin
            for (int j = 0; j < sitda_pkg::DIGITS; j++)
            begin
                if (t[j*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5)
                begin
                    t[j*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                        t[j*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
                end
            end
            t = {t[sitda_pkg::BCD_W-2:0], m[sitda_pkg::MAG_W-1]};
            m = {m[sitda_pkg::MAG_W-2:0], 1'b0};
        end
        bcd_next = t;
        mag_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= CONV;
                        step_reg  <= '0;
                    end
                end
                CONV:
                begin
                    step_reg <= step_reg + sitda_pkg::STEP_W'(1);
                    if (conv_done)
                    begin
                        state_reg <= PUSH;
                    end
                end
                PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= value[31];
            mag_reg <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
            bcd_reg <= '0;
        end
        else if (state_reg == CONV)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

    `ASSERT_PROP(a_accept_busy, clk, rst_n, accept |=> busy, "busy low after transfer")
    `ASSERT_PROP(a_conv_done, clk, rst_n, conv_done |=> (state_reg == PUSH), "dabble overran")
endmodule

>>> hdl/sitda_queue.sv
// Short queue between front end and emitter.
// Depends on sitda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sitda_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sitda_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output sitda_pkg::entry_t head
);
    sitda_pkg::entry_t                 slots_reg [sitda_pkg::QUEUE_DEPTH];
    logic [sitda_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [sitda_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [sitda_pkg::QUEUE_CW-1:0]    count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (count_reg == sitda_pkg::QUEUE_CW'(sitda_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + sitda_pkg::QUEUE_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - sitda_pkg::QUEUE_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !valid, "pop from empty queue")
endmodule

>>> hdl/sitda_back.sv
// Emitter: pops converted values and sends one ASCII character per cycle.
// Depends on sitda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sitda_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sitda_pkg::entry_t               q_head,
    output logic                            q_pop,
    output logic                            strobe,
    output logic [sitda_pkg::CHAR_W-1:0]    character,
    output logic                            last
);
    logic                                   active_reg;
    logic                                   minus_reg;
    logic [sitda_pkg::DIGIT_IDX_W-1:0]      idx_reg;
    sitda_pkg::bcd_t                        digits_reg;
    logic                                   strobe_reg;
    logic [sitda_pkg::CHAR_W-1:0]           character_reg;
    logic                                   last_reg;
    logic                                   final_char;
    logic [sitda_pkg::DIGIT_IDX_W-1:0]      msd;

    assign final_char = active_reg && !minus_reg && (idx_reg == '0);
    // Next value loads while the last character of the current one goes out.
    assign q_pop      = q_valid && (!active_reg || final_char);
    assign strobe     = strobe_reg;
    assign character  = character_reg;
    assign last       = last_reg;

    // Highest nonzero digit; zero keeps a single digit.
    always_comb
    begin
        msd = '0;
        for (int j = 0; j < sitda_pkg::DIGITS; j++)
        begin
            if (q_head.digits[j] != '0)
            begin
                msd = sitda_pkg::DIGIT_IDX_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            digits_reg    <= '0;
            strobe_reg    <= 1'b0;
            character_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (active_reg)
            begin
                if (minus_reg)
                begin
                    character_reg <= sitda_pkg::CHAR_MINUS;
                    last_reg      <= 1'b0;
                    minus_reg     <= 1'b0;
                end
                else
                begin
                    character_reg <= sitda_pkg::CHAR_ZERO
                                   + sitda_pkg::CHAR_W'(digits_reg[idx_reg]);
                    last_reg      <= (idx_reg == '0);
                    if (idx_reg != '0)
                    begin
                        idx_reg <= idx_reg - sitda_pkg::DIGIT_IDX_W'(1);
                    end
                end
            end
            if (q_pop)
            begin
                active_reg <= 1'b1;
                minus_reg  <= q_head.negative;
                idx_reg    <= msd;
                digits_reg <= q_head.digits;
            end
            else if (final_char)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    `ASSERT_PROP(a_run_contiguous, clk, rst_n, (strobe && !last) |=> strobe, "run broken")
    `ASSERT_PROP(a_minus_last, clk, rst_n, (active_reg && minus_reg) |=> !last, "minus last")
endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_front, sitda_queue and sitda_back.
`timescale 1ns / 1ps
// Usage:
//   Input: drive value and raise start; the transfer happens at a rising
//   edge with start high and busy low. Hold start only as long as wanted.
//   Output: one ASCII character per cycle on character, qualified by
//   strobe, most significant first, '-' ahead of negative numbers, no
//   leading zeros, zero as a single '0'. last marks the final character.
//   The receiver cannot stall: each character is valid for one cycle only.
// Timing:
//   The front end converts the magnitude by double dabble, four bits per
//   cycle, then pushes the result; busy stays high through conversion and
//   push, and the push waits while the two-entry queue is full. With the
//   emitter idle, a value passes the queue slot, the emitter's digit
//   registers and its character register before its first character is
//   on the ports; characters then follow back to back. The emitter takes
//   the next value in the cycle its last character leaves, so queued
//   texts follow without a gap; a text has 1 to 11 characters.
// Reset:
//   rst_n is asynchronous, active low; it empties the queue, stops any
//   run in progress and drops busy and strobe.
module signed_int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [31:0]            value,
    output logic                          busy,
    output logic                          strobe,
    output logic [sitda_pkg::CHAR_W-1:0]  character,
    output logic                          last
);
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    sitda_pkg::entry_t q_entry;
    sitda_pkg::entry_t q_head;

    // Sign split and binary to BCD conversion.
    sitda_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .value   (value),
        .busy    (busy),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Decouples conversion from emission.
    sitda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // Leading zero skip and character output.
    sitda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );
endmodule

>>> test/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: drives 32-bit values, predicts the
// decimal ASCII text of each one and checks every strobed character against it.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;

    // Cycles with neither a value transfer nor a character before we give up.
    // Worst honest gap is a long sender pause plus conversion latency.
    localparam int IDLE_LIMIT   = 2000;
    // Quiet cycles after the last character; covers the converter's latency.
    localparam int TAIL_CYCLES  = 40;

    // One character of predicted text.
    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] code;
        logic                         final_char;
    } text_char_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic signed [31:0]           value;
    logic                         busy;
    logic                         strobe;
    logic [sitda_pkg::CHAR_W-1:0] character;
    logic                         last;

    // Predicted characters, oldest first, across all values in flight.
    text_char_t pending_text[$];
    int         mismatch_count;
    int         idle_cycles;
    // Sender pacing: when clear, values go out back to back.
    bit         sender_gaps;

    signed_int_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Decimal text of one value: optional '-', then digits, no leading zeros.
    // The magnitude is taken as unsigned, so the most negative value needs no
    // special handling beyond that.
    function automatic void predict_text(input logic [31:0] raw);
        logic       negative;
        logic [31:0] mag;
        logic [3:0] digit_lsf[10];
        int         ndigits;
        int         total;
        int         pos;
        text_char_t tc;
        negative = raw[31];
        mag      = negative ? (32'd0 - raw) : raw;
        ndigits  = 0;
        if (mag == 32'd0)
        begin
            digit_lsf[0] = 4'd0;
            ndigits      = 1;
        end
        else
        begin
            while (mag != 32'd0)
            begin
                digit_lsf[ndigits] = 4'(mag % 32'd10);
                mag                = mag / 32'd10;
                ndigits++;
            end
        end
        total = ndigits + (negative ? 1 : 0);
        pos   = 0;
        if (negative)
        begin
            tc.code       = sitda_pkg::CHAR_MINUS;
            tc.final_char = (pos == total - 1);
            pending_text.push_back(tc);
            pos++;
        end
        for (int d = ndigits - 1; d >= 0; d--)
        begin
            tc.code       = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit_lsf[d]);
            tc.final_char = (pos == total - 1);
            pending_text.push_back(tc);
            pos++;
        end
    endfunction

    // Value with a uniformly chosen digit count, so short and long texts are
    // about equally common; sign is a coin toss.
    function automatic logic [31:0] pick_value();
        int          ndigits;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mag;
        ndigits = $urandom_range(10, 1);
        lo = 32'd1;
        repeat (ndigits - 1) lo = lo * 32'd10;
        if (ndigits == 1)
        begin
            lo = 32'd0;
            hi = 32'd9;
        end
        else if (ndigits == 10)
            hi = 32'h7FFF_FFFF;
        else
            hi = lo * 32'd10 - 32'd1;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? (32'd0 - mag) : mag;
    endfunction

    // Mostly no gap or a short one, a few long ones, none when gaps are off.
    function automatic int pick_gap();
        int roll;
        if (!sender_gaps)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // One value transfer. Called at a rising edge. start stays high when no
    // gap follows, so the next call raises it again without a dip.
    task automatic send_value(input logic [31:0] v);
        int gap;
        start <= 1'b1;
        value <= v;
        // busy read right after the edge is its pre-edge value, so the
        // transfer happened at the edge where we see it low.
        do
            @(posedge clk);
        while (busy);
        predict_text(v);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            // Junk on value while start is low must be ignored.
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and hold off until every predicted character has shown up.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, zero, digit-count boundaries, and the most negative value.
    task automatic test_directed();
        logic [31:0] corner[$];
        sender_gaps = 1'b1;
        corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                   32'hFFFF_FFF7, 32'd99, 32'd100, 32'd999_999_999,
                   32'd1_000_000_000, 32'd1_234_567_890, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0001, 32'hC465_3600,
                   32'hB669_FD2E, 32'd1_073_741_824, 32'd2_000_000_000,
                   32'd5};
        foreach (corner[i])
            send_value(corner[i]);
    endtask

    // Long run with no sender gaps: short texts here hit the conversion
    // rate, long ones the character rate.
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        repeat (60) send_value(pick_value());
        sender_gaps = 1'b1;
    endtask

    // Bulk traffic over all text lengths with random pacing.
    task automatic test_random_lengths();
        sender_gaps = 1'b1;
        repeat (170) send_value(pick_value());
    endtask

    // Bursts separated by a full drain, so the emitter goes idle mid-test.
    task automatic test_drain_pause();
        sender_gaps = 1'b1;
        repeat (4)
        begin
            repeat (8) send_value(pick_value());
            wait_drained();
            repeat ($urandom_range(6, 0)) @(posedge clk);
        end
    endtask

    // Raw 32-bit patterns: mostly 10-digit texts, every bit toggled.
    task automatic test_raw_bits();
        sender_gaps = 1'b1;
        repeat (36) send_value($urandom);
    endtask

    // Character checker. Outputs are sampled right after the edge, i.e. the
    // values that the edge accepted; the receiver never stalls.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_text.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got %h last %b",
                         $time, character, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (character !== want.code)
                begin
                    $display("%0t: character mismatch: expected %h, got %h",
                             $time, want.code, character);
                    mismatch_count++;
                end
                if (last !== want.final_char)
                begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, want.final_char, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on progress: any value transfer or character resets it.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        idle_cycles    = 0;
        sender_gaps    = 1'b1;
        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_drain_pause();
        test_random_lengths();
        test_raw_bits();

        // Let the tail drain, then watch for stray characters.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/sitda_pkg.sv
hdl/sitda_front.sv
hdl/sitda_queue.sv
hdl/sitda_back.sv
hdl/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
